// ----- sv/cafu_pkg.sv -----
// Package for the cpu_alu_flag_unit block: operation codes, flag bit positions
// and the request and result structs passed between the top level and the ALU.
// No dependencies.
`default_nettype none

package cafu_pkg;

  localparam int unsigned CmdWidth = 5;
  localparam int unsigned FlagWidth = 4;

  // Flag bit positions inside the 4-bit flag word.
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] DaaLowFix = 8'h06;
  localparam logic [7:0] DaaHighFix = 8'h60;
  localparam logic [7:0] DaaHighLimit = 8'h99;
  localparam logic [3:0] DaaLowLimit = 4'h9;

  typedef enum logic [CmdWidth-1:0] {
    CmdAdd   = 5'd0,
    CmdAdc   = 5'd1,
    CmdSub   = 5'd2,
    CmdSbc   = 5'd3,
    CmdAnd   = 5'd4,
    CmdXor   = 5'd5,
    CmdOr    = 5'd6,
    CmdCp    = 5'd7,
    CmdInc   = 5'd8,
    CmdDec   = 5'd9,
    CmdAdd16 = 5'd10,
    CmdRlca  = 5'd11,
    CmdRla   = 5'd12,
    CmdRrca  = 5'd13,
    CmdRra   = 5'd14,
    CmdDaa   = 5'd15,
    CmdCpl   = 5'd16,
    CmdScf   = 5'd17,
    CmdCcf   = 5'd18
  } cmd_e;

  typedef struct packed {
    logic [CmdWidth-1:0] cmd;
    logic [7:0]          acc;
    logic [7:0]          operand;
    logic [15:0]         wide_left;
    logic [15:0]         wide_right;
  } alu_req_t;

  typedef struct packed {
    logic [15:0]          result;
    logic [FlagWidth-1:0] flags;
  } alu_res_t;

endpackage

`default_nettype wire

// ----- sv/cpu_alu_flag_unit_top.sv -----
// An accepted item passes the input register, then the result register, before its result shows valid.
// Throughput: one operation per cycle while out_ready_i stays high;
// the flag register feeds the next item in the input stage.
// The only loop is flags_q -> ALU -> flags_q, one short combinational pass.
// Reset (rst_ni low, asynchronous) clears both stage valids and the four flags to zero.
// Top level of the cpu_alu_flag_unit block: handshake stages and the flag register.
// Depends on cafu_pkg and cafu_alu.
`default_nettype none

module cpu_alu_flag_unit_top
  import cafu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CmdWidth-1:0]  cmd_i,
  input  logic [7:0]           acc_i,
  input  logic [7:0]           operand_i,
  input  logic [15:0]          wide_left_i,
  input  logic [15:0]          wide_right_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          result_o,
  output logic [FlagWidth-1:0] flags_out_o
);

  // Input stage: holds one accepted item until the ALU result can move on
  // into the result register.
  logic                 in_valid_q;
  alu_req_t             req_q;
  alu_req_t             req_d;

  // Result stage and the kept flags.
  logic                 out_valid_q;
  logic [15:0]          result_q;
  logic [FlagWidth-1:0] flags_out_q;
  logic [FlagWidth-1:0] flags_q;

  alu_res_t             alu_res;
  logic                 advance;
  logic                 in_xfer;

  // The item in the input stage moves forward whenever the result register is
  // empty or its result is being taken in this same cycle. The flag register
  // changes only at that moment, so the next item always sees the flags left
  // by the one just ahead of it.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign req_d.cmd        = cmd_i;
  assign req_d.acc        = acc_i;
  assign req_d.operand    = operand_i;
  assign req_d.wide_left  = wide_left_i;
  assign req_d.wide_right = wide_right_i;

  cafu_alu u_alu (
    .req_i   (req_q),
    .flags_i (flags_q),
    .res_o   (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        flags_q     <= alu_res.flags;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= req_d;
    end
    if (advance) begin
      result_q    <= alu_res.result;
      flags_out_q <= alu_res.flags;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign flags_out_o = flags_out_q;

  // A result that has been shown always matches the kept flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (flags_out_q == flags_q))
    else $error("shown flags differ from kept flags");

  // Every item that leaves the input stage shows up as a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  // The kept flags change only when an item moves into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flags changed without an item advancing");

  // An occupied input stage that cannot move blocks new transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !in_ready_o)
    else $error("input accepted while the input stage is stuck");

endmodule

`default_nettype wire

// ----- sv/cafu_alu.sv -----
// Combinational ALU of the cpu_alu_flag_unit block: computes the new value and
// the next flag word from one request and the current flags. Depends on cafu_pkg.
`default_nettype none

module cafu_alu
  import cafu_pkg::*;
(
  input  alu_req_t             req_i,
  input  logic [FlagWidth-1:0] flags_i,
  output alu_res_t             res_o
);

  logic [7:0]  a;
  logic [7:0]  v;
  logic        cin;
  logic        use_carry;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_nib;
  logic [7:0]  inc_val;
  logic [7:0]  dec_val;
  logic [16:0] wide_sum;
  logic [12:0] wide_nib;
  logic        daa_neg;
  logic        daa_low;
  logic        daa_high;
  logic [7:0]  daa_off;
  logic [7:0]  daa_val;
  logic [7:0]  res8;
  logic [FlagWidth-1:0] nf;
  logic        wide_op;

  assign a   = req_i.acc;
  assign v   = req_i.operand;
  assign cin = flags_i[FlagC];

  assign use_carry = (req_i.cmd == CmdAdc || req_i.cmd == CmdSbc) ? cin : 1'b0;

  assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, use_carry};
  assign add_nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_carry};
  assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, use_carry};
  assign sub_nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_carry};
  assign inc_val  = v + 8'd1;
  assign dec_val  = v - 8'd1;
  assign wide_sum = {1'b0, req_i.wide_left} + {1'b0, req_i.wide_right};
  assign wide_nib = {1'b0, req_i.wide_left[11:0]} + {1'b0, req_i.wide_right[11:0]};

  // Decimal adjust: the correction depends on whether the last operation
  // was a subtraction and on the kept half-carry and carry.
  assign daa_neg  = flags_i[FlagN];
  assign daa_low  = (!daa_neg && (a[3:0] > DaaLowLimit)) || flags_i[FlagH];
  assign daa_high = (!daa_neg && (a > DaaHighLimit)) || cin;
  assign daa_off  = (daa_low ? DaaLowFix : 8'd0) | (daa_high ? DaaHighFix : 8'd0);
  assign daa_val  = daa_neg ? (a - daa_off) : (a + daa_off);

  always_comb begin
    res8    = a;
    nf      = flags_i;
    wide_op = 1'b0;
    case (req_i.cmd)
      CmdAdd, CmdAdc: begin
        res8 = add_sum[7:0];
        nf   = {add_sum[7:0] == 8'd0, 1'b0, add_nib[4], add_sum[8]};
      end
      CmdSub, CmdSbc, CmdCp: begin
        res8 = (req_i.cmd == CmdCp) ? a : sub_diff[7:0];
        nf   = {sub_diff[7:0] == 8'd0, 1'b1, sub_nib[4], sub_diff[8]};
      end
      CmdAnd: begin
        res8 = a & v;
        nf   = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      CmdXor: begin
        res8 = a ^ v;
        nf   = {(a ^ v) == 8'd0, 3'b000};
      end
      CmdOr: begin
        res8 = a | v;
        nf   = {(a | v) == 8'd0, 3'b000};
      end
      CmdInc: begin
        res8 = inc_val;
        nf   = {inc_val == 8'd0, 1'b0, v[3:0] == 4'hF, cin};
      end
      CmdDec: begin
        res8 = dec_val;
        nf   = {dec_val == 8'd0, 1'b1, v[3:0] == 4'h0, cin};
      end
      CmdAdd16: begin
        wide_op = 1'b1;
        nf      = {flags_i[FlagZ], 1'b0, wide_nib[12], wide_sum[16]};
      end
      CmdRlca: begin
        res8 = {a[6:0], a[7]};
        nf   = {3'b000, a[7]};
      end
      CmdRla: begin
        res8 = {a[6:0], cin};
        nf   = {3'b000, a[7]};
      end
      CmdRrca: begin
        res8 = {a[0], a[7:1]};
        nf   = {3'b000, a[0]};
      end
      CmdRra: begin
        res8 = {cin, a[7:1]};
        nf   = {3'b000, a[0]};
      end
      CmdDaa: begin
        res8 = daa_val;
        nf   = {daa_val == 8'd0, daa_neg, 1'b0, daa_high};
      end
      CmdCpl: begin
        res8 = ~a;
        nf   = {flags_i[FlagZ], 1'b1, 1'b1, cin};
      end
      CmdScf: begin
        nf = {flags_i[FlagZ], 1'b0, 1'b0, 1'b1};
      end
      CmdCcf: begin
        nf = {flags_i[FlagZ], 1'b0, 1'b0, !cin};
      end
      default: begin
        // Unused codes leave the flags alone and pass the accumulator.
        res8 = a;
        nf   = flags_i;
      end
    endcase
  end

  assign res_o.result = wide_op ? wide_sum[15:0] : {8'd0, res8};
  assign res_o.flags  = nf;

endmodule

`default_nettype wire
